// File: hdl/wgdr_pkg.sv
// Shared types, codes and helper functions for the wait-graph deadlock recovery core.
`default_nettype none
package wgdr_pkg;

  localparam int unsigned MAX_SITES = 8;
  localparam int unsigned SITE_W    = 3;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned MATRIX_W  = 64;
  localparam int unsigned PRIO_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned EVENT_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SITE_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_MATRIX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_ORDER = 2'd2;

  localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_STILL     = 3'd1;
  localparam logic [EVENT_W-1:0] EV_RECOVERED = 3'd2;
  localparam logic [EVENT_W-1:0] EV_ALL_GONE  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_FEW_SITES = 3'd4;
  localparam logic [EVENT_W-1:0] EV_BAD_START = 3'd5;

  localparam logic [CNT_W-1:0] SITE_COUNT_RST = 4'd8;
  localparam logic [PRIO_W-1:0] PRIO_RST      = 24'd16434824;

  typedef struct packed {
    logic              start;
    logic [SITE_W-1:0] probe;
    logic [MASK_W-1:0] live;
  } reach_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } reach_res_t;

  function automatic logic [SITE_W-1:0] lowest_site(input logic [MASK_W-1:0] mask);
    logic [SITE_W-1:0] s;
    logic              found;
    s = '0;
    found = 1'b0;
    for (int i = 0; i < MASK_W; i++) begin
      if (mask[i] && !found) begin
        s = SITE_W'(i);
        found = 1'b1;
      end
    end
    return s;
  endfunction

  function automatic logic [SITE_W-1:0] pick_victim(input logic [CNT_W-1:0] n,
                                                    input logic [MASK_W-1:0] live,
                                                    input logic [PRIO_W-1:0] prio);
    logic [SITE_W-1:0] s;
    logic [SITE_W-1:0] v;
    logic              found;
    v = lowest_site(live);
    found = 1'b0;
    for (int r = 0; r < MAX_SITES; r++) begin
      s = prio[r*SITE_W +: SITE_W];
      if (!found && (CNT_W'(r) < n) && ({1'b0, s} < n) && live[s]) begin
        v = s;
        found = 1'b1;
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hdl/wgdr_reach.sv
// Iterative reachability unit: sweeps matrix rows one per cycle until the reached set settles.
`default_nettype none
module wgdr_reach
  import wgdr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [MATRIX_W-1:0] matrix_i,
  input  wire reach_req_t          req_i,
  output reach_res_t               res_o
);

  logic              busy_q, seed_q, chg_q, done_q, hit_q;
  logic [SITE_W-1:0] idx_q, probe_q;
  logic [MASK_W-1:0] live_q, reached_q;

  logic [SITE_W-1:0] sel;
  logic [MASK_W-1:0] row, add, reached_d;
  logic              grew;

  always_comb begin
    sel       = seed_q ? probe_q : idx_q;
    row       = matrix_i[{sel, 3'b000} +: MASK_W] & live_q;
    add       = (seed_q || reached_q[idx_q]) ? row : '0;
    reached_d = reached_q | add;
    grew      = reached_d != reached_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      seed_q <= 1'b0;
      chg_q  <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        seed_q <= 1'b1;
        chg_q  <= 1'b0;
        idx_q  <= '0;
      end else if (busy_q) begin
        if (seed_q) begin
          seed_q <= 1'b0;
        end else if (idx_q == SITE_W'(MASK_W - 1)) begin
          idx_q <= '0;
          chg_q <= 1'b0;
          if (!(chg_q || grew)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end else begin
          idx_q <= idx_q + 1'b1;
          chg_q <= chg_q | grew;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      probe_q   <= req_i.probe;
      live_q    <= req_i.live;
      reached_q <= '0;
    end else if (busy_q) begin
      reached_q <= reached_d;
      hit_q     <= reached_d[probe_q];
    end
  end

  assign res_o.done = done_q;
  assign res_o.hit  = hit_q;

  ap_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |-> !busy_q) else $error("reach done while busy");
  ap_seed_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> (busy_q && seed_q && idx_q == '0)) else $error("reach start not seeded");
  ap_no_done_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_q |=> !res_o.done) else $error("reach done straight after seed");

endmodule
`default_nettype wire

// File: hdl/wait_graph_deadlock_recovery_core.sv
// Top level: request sequencer, victim selection, config registers and result register.
// An error result passes through the emit state and then the output register; a probe first
// seeds from the probe site, then sweeps the matrix rows until a whole pass adds no site, and
// each kill and result takes its own state. Only one request is taken at a time.
// A result waiting in the output register stalls the sequencer only when another is due.
// Reset: asynchronous, active low; clears control and restores config register defaults.
`default_nettype none
module wait_graph_deadlock_recovery_core
  import wgdr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [2:0] start_site
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [2:0] event_res, [5:3] victim
  output logic                      m_axis_tlast,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [MATRIX_W-1:0]  cfg_data_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_KILL  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    site_count_q;
  logic [MATRIX_W-1:0] wait_matrix_q;
  logic [PRIO_W-1:0]   prio_q;

  logic [CNT_W-1:0]    n_q;
  logic [MASK_W-1:0]   all_q, kill_q, live_q;
  logic                first_q;
  logic [SITE_W-1:0]   vic_q;
  logic [EVENT_W-1:0]  res_ev_q;
  logic [SITE_W-1:0]   res_vic_q;
  logic                res_last_q;

  logic                out_valid_q, out_last_q;
  logic [EVENT_W-1:0]  out_ev_q;
  logic [SITE_W-1:0]   out_vic_q;

  logic [CNT_W-1:0]    n_cur;
  logic [MASK_W-1:0]   all_cur, live_new;
  logic [SITE_W-1:0]   start, vic_new;
  logic                in_acc, out_free;
  reach_req_t          reach_req;
  reach_res_t          reach_res;

  wgdr_reach u_reach (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .matrix_i (wait_matrix_q),
    .req_i    (reach_req),
    .res_o    (reach_res)
  );

  always_comb begin
    n_cur = (site_count_q > CNT_W'(MAX_SITES)) ? CNT_W'(MAX_SITES) : site_count_q;
    for (int i = 0; i < MASK_W; i++) begin
      all_cur[i] = CNT_W'(i) < n_cur;
    end
    start    = s_axis_tdata[SITE_W-1:0];
    in_acc   = s_axis_tvalid && s_axis_tready;
    out_free = !out_valid_q || m_axis_tready;
    vic_new  = pick_victim(n_q, live_q, prio_q);
    live_new = live_q & ~(MASK_W'(1) << vic_new);
  end

  assign s_axis_tready = state_q == ST_IDLE;

  always_comb begin
    state_d         = state_q;
    reach_req.start = 1'b0;
    reach_req.probe = lowest_site(live_q);
    reach_req.live  = live_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (n_cur < CNT_W'(2) || {1'b0, start} >= n_cur) begin
            state_d = ST_EMIT;
          end else begin
            state_d         = ST_PROBE;
            reach_req.start = 1'b1;
            reach_req.probe = start;
            reach_req.live  = all_cur;
          end
        end
      end
      ST_PROBE: begin
        if (reach_res.done) begin
          state_d = (reach_res.hit && first_q) ? ST_KILL : ST_EMIT;
        end
      end
      ST_KILL: begin
        if (live_new == '0) begin
          state_d = ST_EMIT;
        end else begin
          state_d         = ST_PROBE;
          reach_req.start = 1'b1;
          reach_req.probe = lowest_site(live_new);
          reach_req.live  = live_new;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = res_last_q ? ST_IDLE : ST_KILL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      site_count_q  <= SITE_COUNT_RST;
      wait_matrix_q <= '0;
      prio_q        <= PRIO_RST;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SITE_COUNT:     site_count_q  <= cfg_data_i[CNT_W-1:0];
          REG_WAIT_MATRIX:    wait_matrix_q <= cfg_data_i;
          REG_PRIORITY_ORDER: prio_q        <= cfg_data_i[PRIO_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          n_q        <= n_cur;
          all_q      <= all_cur;
          live_q     <= all_cur;
          kill_q     <= '0;
          first_q    <= 1'b1;
          res_vic_q  <= '0;
          res_last_q <= 1'b1;
          res_ev_q   <= (n_cur < CNT_W'(2)) ? EV_FEW_SITES : EV_BAD_START;
        end
      end
      ST_PROBE: begin
        if (reach_res.done) begin
          if (!reach_res.hit) begin
            res_ev_q   <= first_q ? EV_NONE : EV_RECOVERED;
            res_vic_q  <= first_q ? '0 : vic_q;
            res_last_q <= 1'b1;
          end else begin
            res_ev_q   <= EV_STILL;
            res_vic_q  <= vic_q;
            res_last_q <= first_q;
          end
        end
      end
      ST_KILL: begin
        first_q    <= 1'b0;
        vic_q      <= vic_new;
        live_q     <= live_new;
        kill_q     <= kill_q | (MASK_W'(1) << vic_new);
        res_ev_q   <= EV_ALL_GONE;
        res_vic_q  <= vic_new;
        res_last_q <= 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_ev_q   <= res_ev_q;
          out_vic_q  <= res_vic_q;
          out_last_q <= res_last_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_vic_q, out_ev_q};
  assign m_axis_tlast  = out_last_q;

  ap_live_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_EMIT) |-> (live_q == (all_q & ~kill_q)))
    else $error("live mask out of step with kill mask");
  ap_probe_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PROBE |-> live_q != '0) else $error("probe with no live site");
  ap_done_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reach_res.done |-> state_q == ST_PROBE) else $error("reach done outside probe");
  ap_kill_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_KILL |-> (live_q & (MASK_W'(1) << vic_new)) != '0)
    else $error("victim not live");

endmodule
`default_nettype wire
